### rtl/core/mosa_pkg.sv
// ----------------------------------------------------------------------------
// mosa_pkg
// shared types and codes for the two-array median block
// ----------------------------------------------------------------------------
`default_nettype none

package mosa_pkg;

   localparam int ElemWidth   = 32;
   localparam int ResultWidth = 33;

   localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
   localparam logic [1:0] MODE_COMPUTE     = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_STEP,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      SEL_FIRST,
      SEL_SECOND,
      SEL_MIN
   } sel_type;

endpackage

`default_nettype wire

### rtl/core/mosa_ram.sv
// ----------------------------------------------------------------------------
// mosa_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module mosa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/core/median_of_two_sorted_arrays.sv
// ----------------------------------------------------------------------------
// median_of_two_sorted_arrays
// twice the median of two loaded ascending arrays by k-th smallest selection
// ----------------------------------------------------------------------------
// Load items (mode 0 or 1) may follow back to back;
// a load into a full array is discarded and flagged on the next result.
// A compute item (mode 2) holds busy high while the selection runs: each
// halving step reads both arrays, then compares, since the two array rams
// give registered read data; an even total runs two selection passes. With
// both arrays empty the result comes in the cycle after the item. The result
// is shown for one cycle on rsp_valid and cannot be held off; the compute
// clears both counts for the next job.
// ----------------------------------------------------------------------------
`default_nettype none

module median_of_two_sorted_arrays
   import mosa_pkg::*;
#(
   parameter int ARRAY_DEPTH = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_mode,
   input  wire logic signed [ElemWidth-1:0]   req_value,
   output logic                               rsp_valid,
   output logic signed [ResultWidth-1:0]      rsp_median_twice,
   output logic                               rsp_empty_error,
   output logic                               rsp_dropped
);

   localparam int AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
   localparam int CW = $clog2(ARRAY_DEPTH + 1);
   localparam int KW = CW + 1;
   localparam logic [CW-1:0] DepthCount = CW'(ARRAY_DEPTH);

   state_type state_ff, state_in;
   sel_type   sel_ff, sel_in;
   logic [CW-1:0] first_count_ff, first_count_in;
   logic [CW-1:0] second_count_ff, second_count_in;
   logic          overflow_ff, overflow_in;
   logic [CW-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic [CW-1:0] ia_ff, ia_in, ib_ff, ib_in;
   logic [KW-1:0] k_ff, k_in;
   logic          pass_ff, pass_in;
   logic signed [ResultWidth-1:0] acc_ff, acc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic signed [ResultWidth-1:0] median_ff, median_in;
   logic          error_ff, error_in;
   logic          dropped_ff, dropped_in;

   logic          wr_first, wr_second;
   logic [AW-1:0] rd_addr_first, rd_addr_second;
   logic [ElemWidth-1:0] rd_first, rd_second;

   logic [KW-1:0] total, half, ia_full, ib_full, na_m1, nb_m1, ia_cl, ib_cl;
   logic [KW-1:0] term_a, term_b;
   logic          accept;
   logic signed [ElemWidth-1:0] pick;
   logic signed [ResultWidth-1:0] pick_ext;

   mosa_ram #(.WIDTH(ElemWidth), .DEPTH(ARRAY_DEPTH)) u_first_ram (
      .clock   (clock),
      .wr_en   (wr_first),
      .wr_addr (first_count_ff[AW-1:0]),
      .wr_data (req_value),
      .rd_addr (rd_addr_first),
      .rd_data (rd_first)
   );

   mosa_ram #(.WIDTH(ElemWidth), .DEPTH(ARRAY_DEPTH)) u_second_ram (
      .clock   (clock),
      .wr_en   (wr_second),
      .wr_addr (second_count_ff[AW-1:0]),
      .wr_data (req_value),
      .rd_addr (rd_addr_second),
      .rd_data (rd_second)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign total  = {1'b0, first_count_ff} + {1'b0, second_count_ff};
   assign half   = k_ff >> 1;
   assign ia_full = {1'b0, pa_ff} + half - KW'(1);
   assign ib_full = {1'b0, pb_ff} + half - KW'(1);
   assign na_m1  = {1'b0, first_count_ff} - KW'(1);
   assign nb_m1  = {1'b0, second_count_ff} - KW'(1);
   assign ia_cl  = (ia_full > na_m1) ? na_m1 : ia_full;
   assign ib_cl  = (ib_full > nb_m1) ? nb_m1 : ib_full;
   assign term_a = {1'b0, pa_ff} + k_ff - KW'(1);
   assign term_b = {1'b0, pb_ff} + k_ff - KW'(1);

   always_comb begin
      unique case (sel_ff)
         SEL_FIRST:  pick = $signed(rd_first);
         SEL_SECOND: pick = $signed(rd_second);
         default:    pick = ($signed(rd_first) < $signed(rd_second)) ?
                            $signed(rd_first) : $signed(rd_second);
      endcase
      pick_ext = ResultWidth'(pick);
   end

   always_comb begin
      state_in        = state_ff;
      sel_in          = sel_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      overflow_in     = overflow_ff;
      pa_in           = pa_ff;
      pb_in           = pb_ff;
      ia_in           = ia_ff;
      ib_in           = ib_ff;
      k_in            = k_ff;
      pass_in         = pass_ff;
      acc_in          = acc_ff;
      rsp_valid_in    = 1'b0;
      median_in       = median_ff;
      error_in        = error_ff;
      dropped_in      = dropped_ff;
      wr_first        = 1'b0;
      wr_second       = 1'b0;
      rd_addr_first   = pa_ff[AW-1:0];
      rd_addr_second  = pb_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  MODE_LOAD_FIRST: begin
                     if (first_count_ff < DepthCount) begin
                        wr_first       = 1'b1;
                        first_count_in = first_count_ff + CW'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  MODE_LOAD_SECOND: begin
                     if (second_count_ff < DepthCount) begin
                        wr_second       = 1'b1;
                        second_count_in = second_count_ff + CW'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  MODE_COMPUTE: begin
                     if (total == '0) begin
                        rsp_valid_in    = 1'b1;
                        median_in       = '0;
                        error_in        = 1'b1;
                        dropped_in      = overflow_ff;
                        first_count_in  = '0;
                        second_count_in = '0;
                        overflow_in     = 1'b0;
                     end else begin
                        pa_in    = '0;
                        pb_in    = '0;
                        pass_in  = 1'b0;
                        k_in     = total[0] ? ((total + KW'(1)) >> 1) : (total >> 1);
                        state_in = ST_CHECK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if (pa_ff >= first_count_ff) begin
               rd_addr_second = term_b[AW-1:0];
               sel_in         = SEL_SECOND;
               state_in       = ST_RESULT;
            end else if (pb_ff >= second_count_ff) begin
               rd_addr_first = term_a[AW-1:0];
               sel_in        = SEL_FIRST;
               state_in      = ST_RESULT;
            end else if (k_ff <= KW'(1)) begin
               sel_in   = SEL_MIN;
               state_in = ST_RESULT;
            end else begin
               rd_addr_first  = ia_cl[AW-1:0];
               rd_addr_second = ib_cl[AW-1:0];
               ia_in          = ia_cl[CW-1:0];
               ib_in          = ib_cl[CW-1:0];
               state_in       = ST_STEP;
            end
         end
         ST_STEP: begin
            if ($signed(rd_first) <= $signed(rd_second)) begin
               k_in  = k_ff - ({1'b0, ia_ff} - {1'b0, pa_ff} + KW'(1));
               pa_in = ia_ff + CW'(1);
            end else begin
               k_in  = k_ff - ({1'b0, ib_ff} - {1'b0, pb_ff} + KW'(1));
               pb_in = ib_ff + CW'(1);
            end
            state_in = ST_CHECK;
         end
         ST_RESULT: begin
            if (!pass_ff && !total[0]) begin
               acc_in   = pick_ext;
               pass_in  = 1'b1;
               pa_in    = '0;
               pb_in    = '0;
               k_in     = (total >> 1) + KW'(1);
               state_in = ST_CHECK;
            end else begin
               rsp_valid_in    = 1'b1;
               median_in       = pass_ff ? (acc_ff + pick_ext) : {pick, 1'b0};
               error_in        = 1'b0;
               dropped_in      = overflow_ff;
               first_count_in  = '0;
               second_count_in = '0;
               overflow_in     = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         overflow_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         overflow_ff     <= overflow_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff     <= sel_in;
      pa_ff      <= pa_in;
      pb_ff      <= pb_in;
      ia_ff      <= ia_in;
      ib_ff      <= ib_in;
      k_ff       <= k_in;
      pass_ff    <= pass_in;
      acc_ff     <= acc_in;
      median_ff  <= median_in;
      error_ff   <= error_in;
      dropped_ff <= dropped_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_twice = median_ff;
   assign rsp_empty_error  = error_ff;
   assign rsp_dropped      = dropped_ff;

   // result only right after a compute, with the job state cleared
   a_rsp_clears_job: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (first_count_ff == '0 && second_count_ff == '0 && !overflow_ff))
      else $error("job state not cleared with result");

   // counts frozen while the selection runs
   a_counts_stable: assert property (@(posedge clock) disable iff (reset)
      (busy && $past(busy)) |-> ($stable(first_count_ff) && $stable(second_count_ff)))
      else $error("counts changed during selection");

   // compare indices stay inside the loaded arrays
   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (ia_ff < first_count_ff && ib_ff < second_count_ff))
      else $error("selection index out of range");

   // a multi-cycle compute ends in a result
   a_done_has_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && $past(state_ff) == ST_RESULT) |-> rsp_valid)
      else $error("selection ended without result");

endmodule

`default_nettype wire
